/* src/olid_pkg.sv */
package olid_pkg;

    // List sizing. The store has 2**IDX_W cells; the list may be capped lower.
    localparam int CAPACITY  = 32;
    localparam int IDX_W     = 5;
    localparam int CELLS     = 1 << IDX_W;
    localparam int CAP_LIMIT = (CAPACITY < CELLS) ? CAPACITY : CELLS;
    localparam int CNT_W     = IDX_W + 1;
    localparam int DATA_W    = 32;

    // Command codes.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_BADIDX = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_READ,
        ST_RESP
    } state_t;

    // Access request from the controller to the entry store.
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
    } ram_req_t;

endpackage

/* src/olid_ram.sv */
module olid_ram (
    input  logic                          aclk,
    input  olid_pkg::ram_req_t            req,
    output logic [olid_pkg::DATA_W-1:0]   rd_data
);

    logic [olid_pkg::DATA_W-1:0] mem [olid_pkg::CELLS];
    logic [olid_pkg::DATA_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // One read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/ordered_list_insert_delete_core.sv */
// Ordered list of up to CAPACITY signed 32-bit values held in an entry memory
// with one write port and one registered read port.
// Input channel (s_valid/s_ready) takes one command per beat: append, insert
// at a position, delete at a position, or read out. The result channel
// (m_valid/m_ready) returns one beat per command, or one beat per entry for a
// read out, with m_last on the final beat of each command.
// Append and every rejected command put their result in the output register
// from the response state once that register is free. Insert and delete
// move one entry per cycle (a read, written back one cell over in the next
// cycle), and then pass to the response state. A read out emits one entry
// per cycle while the receiver takes them, waiting whenever it stalls.
// A new command is accepted whenever the controller is idle, in the cycle
// after the final result beat of the previous command is loaded, even
// while that result still waits in the output register.
// When the receiver stalls, the result stays in the output register and the
// controller waits; a read out resumes where it stopped.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; the memory itself is not cleared, since only entries below the
// length are ever read.
module ordered_list_insert_delete_core (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [5:0]          s_position,
    input  logic signed [31:0]  s_value,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic signed [31:0]  m_entry_value,
    output logic [4:0]          m_entry_index,
    output logic [5:0]          m_length,
    output logic                m_last
);

    localparam int IDX_W  = olid_pkg::IDX_W;
    localparam int CNT_W  = olid_pkg::CNT_W;
    localparam int DATA_W = olid_pkg::DATA_W;

    olid_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               ins_reg, ins_next;
    logic [IDX_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [1:0]         status_reg, status_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg;
    logic [DATA_W-1:0]  m_entry_value_reg;
    logic [IDX_W-1:0]   m_entry_index_reg;
    logic [CNT_W-1:0]   m_length_reg;
    logic               m_last_reg;

    logic               out_load;
    logic [1:0]         o_status;
    logic [DATA_W-1:0]  o_value;
    logic [IDX_W-1:0]   o_index;
    logic               o_last;

    logic               slot_free;
    logic               list_full;
    logic               last_hit;

    olid_pkg::ram_req_t ram_req;
    logic [DATA_W-1:0]  rd_data;

    olid_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign list_full = (count_reg >= CNT_W'(olid_pkg::CAP_LIMIT));
    assign last_hit  = (({1'b0, rd_idx_reg} + CNT_W'(1)) == count_reg);
    assign s_ready   = (state_reg == olid_pkg::ST_IDLE);

    // Controller: command decode, memory walk for insert and delete, read out.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        ins_next       = ins_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rd_idx_next    = rd_idx_reg;
        status_next    = status_reg;

        ram_req         = '0;
        out_load        = 1'b0;
        o_status        = olid_pkg::STAT_DONE;
        o_value         = '0;
        o_index         = '0;
        o_last          = 1'b1;

        case (state_reg)
            olid_pkg::ST_IDLE: begin
                if (s_valid) begin
                    status_next = olid_pkg::STAT_DONE;
                    case (s_cmd)
                        olid_pkg::CMD_APPEND: begin
                            state_next = olid_pkg::ST_RESP;
                            if (list_full) begin
                                status_next = olid_pkg::STAT_FULL;
                            end else begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = count_reg[IDX_W-1:0];
                                ram_req.wr_data = $unsigned(s_value);
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        olid_pkg::CMD_INSERT: begin
                            if (s_position > count_reg) begin
                                status_next = olid_pkg::STAT_BADIDX;
                                state_next  = olid_pkg::ST_RESP;
                            end else if (list_full) begin
                                status_next = olid_pkg::STAT_FULL;
                                state_next  = olid_pkg::ST_RESP;
                            end else begin
                                val_next   = $unsigned(s_value);
                                pos_next   = s_position[IDX_W-1:0];
                                ins_next   = 1'b1;
                                left_next  = count_reg - s_position;
                                src_next   = count_reg[IDX_W-1:0] - IDX_W'(1);
                                pend_next  = 1'b0;
                                state_next = olid_pkg::ST_MOVE;
                            end
                        end
                        olid_pkg::CMD_DELETE: begin
                            if (s_position >= count_reg) begin
                                status_next = olid_pkg::STAT_BADIDX;
                                state_next  = olid_pkg::ST_RESP;
                            end else begin
                                pos_next   = s_position[IDX_W-1:0];
                                ins_next   = 1'b0;
                                left_next  = count_reg - s_position - CNT_W'(1);
                                src_next   = s_position[IDX_W-1:0] + IDX_W'(1);
                                pend_next  = 1'b0;
                                state_next = olid_pkg::ST_MOVE;
                            end
                        end
                        olid_pkg::CMD_READ: begin
                            if (count_reg == '0) begin
                                status_next = olid_pkg::STAT_EMPTY;
                                state_next  = olid_pkg::ST_RESP;
                            end else begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = '0;
                                rd_idx_next     = '0;
                                state_next      = olid_pkg::ST_READ;
                            end
                        end
                        default: begin
                            state_next = olid_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // Shift entries one cell a cycle: read the source, write it back
            // one cell up (insert) or down (delete) in the next cycle.
            olid_pkg::ST_MOVE: begin
                if (pend_reg) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = pend_addr_reg;
                    ram_req.wr_data = rd_data;
                end
                if (left_reg != '0) begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = src_reg;
                    pend_next       = 1'b1;
                    pend_addr_next  = ins_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    src_next        = ins_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                    left_next       = left_reg - CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (ins_reg) begin
                            ram_req.wr_en   = 1'b1;
                            ram_req.wr_addr = pos_reg;
                            ram_req.wr_data = val_reg;
                            count_next      = count_reg + CNT_W'(1);
                        end else begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        state_next = olid_pkg::ST_RESP;
                    end
                end
            end

            // Read out: one entry per beat, the next read issued as one leaves.
            olid_pkg::ST_READ: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    o_status = olid_pkg::STAT_DONE;
                    o_value  = rd_data;
                    o_index  = rd_idx_reg;
                    o_last   = last_hit;
                    if (last_hit) begin
                        state_next = olid_pkg::ST_IDLE;
                    end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = rd_idx_reg + IDX_W'(1);
                        rd_idx_next     = rd_idx_reg + IDX_W'(1);
                    end
                end
            end

            olid_pkg::ST_RESP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    o_status   = status_reg;
                    state_next = olid_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = olid_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olid_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        val_reg       <= val_next;
        pos_reg       <= pos_next;
        ins_reg       <= ins_next;
        src_reg       <= src_next;
        left_reg      <= left_next;
        pend_addr_reg <= pend_addr_next;
        rd_idx_reg    <= rd_idx_next;
        status_reg    <= status_next;
    end

    // Result payload register; the length always reflects the list after the command.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg      <= o_status;
            m_entry_value_reg <= o_value;
            m_entry_index_reg <= o_index;
            m_length_reg      <= count_reg;
            m_last_reg        <= o_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = $signed(m_entry_value_reg);
    assign m_entry_index = m_entry_index_reg;
    assign m_length      = m_length_reg;
    assign m_last        = m_last_reg;

    // The list never grows past its cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(olid_pkg::CAP_LIMIT))
        else $error("list length exceeds capacity");

    // The shift walk never reads a cell in the same cycle it writes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.wr_en && ram_req.rd_en) |-> (ram_req.wr_addr != ram_req.rd_addr))
        else $error("memory read and write collide on one cell");

    // A read out leaves the length untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == olid_pkg::ST_READ) |=> $stable(count_reg))
        else $error("length changed during read out");

endmodule
